/* hdl/ybd_pkg.sv */
package ybd_pkg;

    localparam int THUMB_SIDE   = 16;
    localparam int BLOCK_FACTOR = 4;
    localparam int BLOCK_AREA   = BLOCK_FACTOR * BLOCK_FACTOR;

    localparam int TC_W  = $clog2(THUMB_SIDE);
    localparam int SUB_W = (BLOCK_FACTOR > 1) ? $clog2(BLOCK_FACTOR) : 1;
    localparam int ACC_W = $clog2(BLOCK_AREA * 255 + 1);

    localparam int DIV_K  = ACC_W + $clog2(BLOCK_AREA);
    localparam int DIV_M  = (2 ** DIV_K + BLOCK_AREA - 1) / BLOCK_AREA;
    localparam int DIV_MW = ACC_W + 2;
    localparam int PROD_W = ACC_W + DIV_MW;

    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef logic [TC_W-1:0]   tc_t;
    typedef logic [SUB_W-1:0]  sub_t;
    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CNT_W:0]    occ_t;
    typedef logic [PROD_W-1:0] prod_t;

    typedef struct packed {
        acc_t luma;
        acc_t cb;
        acc_t cr;
    } acc_word_t;

    typedef struct packed {
        logic [3:0] thumb_col;
        logic [3:0] thumb_row;
        logic [7:0] luma_avg;
        logic       chroma_valid;
        logic [7:0] cb_avg;
        logic [7:0] cr_avg;
        logic       frame_last;
    } result_t;

    function automatic logic [7:0] block_avg(input acc_t sum);
        prod_t prod;
        prod = prod_t'(sum) * prod_t'(DIV_M);
        return 8'(prod >> DIV_K);
    endfunction

endpackage

/* hdl/ybd_if.sv */
interface ybd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;

    modport source (output valid, output luma_in, output cb_in, output cr_in, input ready);
    modport sink   (input valid, input luma_in, input cb_in, input cr_in, output ready);
endinterface

interface ybd_thumb_if;
    logic       valid;
    logic       ready;
    logic [3:0] thumb_col;
    logic [3:0] thumb_row;
    logic [7:0] luma_avg;
    logic       chroma_valid;
    logic [7:0] cb_avg;
    logic [7:0] cr_avg;
    logic       frame_last;

    modport source (
        output valid, output thumb_col, output thumb_row, output luma_avg,
        output chroma_valid, output cb_avg, output cr_avg, output frame_last,
        input ready
    );
    modport sink (
        input valid, input thumb_col, input thumb_row, input luma_avg,
        input chroma_valid, input cb_avg, input cr_avg, input frame_last,
        output ready
    );
endinterface

/* hdl/ybd_out_fifo.sv */
module ybd_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ybd_pkg::result_t    push_word,
    output ybd_pkg::cnt_t       count,
    ybd_thumb_if.source         thumb
);

    ybd_pkg::result_t queue_reg [ybd_pkg::OUT_DEPTH];
    ybd_pkg::ptr_t    wr_ptr_reg;
    ybd_pkg::ptr_t    wr_ptr_next;
    ybd_pkg::ptr_t    rd_ptr_reg;
    ybd_pkg::ptr_t    rd_ptr_next;
    ybd_pkg::cnt_t    count_reg;
    ybd_pkg::cnt_t    count_next;
    ybd_pkg::result_t head;
    logic             pop;

    assign head  = queue_reg[rd_ptr_reg];
    assign pop   = thumb.valid && thumb.ready;
    assign count = count_reg;

    assign thumb.valid        = (count_reg != '0);
    assign thumb.thumb_col    = head.thumb_col;
    assign thumb.thumb_row    = head.thumb_row;
    assign thumb.luma_avg     = head.luma_avg;
    assign thumb.chroma_valid = head.chroma_valid;
    assign thumb.cb_avg       = head.cb_avg;
    assign thumb.cr_avg       = head.cr_avg;
    assign thumb.frame_last   = head.frame_last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ybd_pkg::ptr_t'(ybd_pkg::OUT_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + ybd_pkg::ptr_t'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ybd_pkg::ptr_t'(ybd_pkg::OUT_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + ybd_pkg::ptr_t'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + ybd_pkg::cnt_t'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - ybd_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* hdl/yuv_box_downsample_420.sv */
// Box-filter downsampler: takes a square YUV image, one pixel word per cycle in raster
// order while ready is high, and returns one thumbnail word per completed block with its
// floor-average luma; on odd thumbnail rows and columns the word also carries the 4:2:0
// chroma average of the 2x2 group of block chroma averages. Pixels are accepted at one
// per cycle while ready is high: the per-column block sums live in a synchronous memory
// that is read at acceptance and written back in the cycle after, with forwarding between
// neighboring pixels of the same block column. A result word passes through the s1, s2
// and s3 registers after its block's last pixel is accepted, then through an eight-word
// output queue; ready drops only while that queue together with the results still in the
// pipeline would be full. No clearing pass is needed after reset.
module yuv_box_downsample_420 (
    input  logic        clk,
    input  logic        rst_n,
    ybd_pix_if.sink     pix,
    ybd_thumb_if.source thumb
);

    typedef struct packed {
        logic [7:0] cb;
        logic [7:0] cr;
    } chroma_pair_t;

    logic               accept;
    logic               done_in;

    ybd_pkg::sub_t      col_sub_reg;
    ybd_pkg::sub_t      col_sub_next;
    ybd_pkg::tc_t       col_blk_reg;
    ybd_pkg::tc_t       col_blk_next;
    ybd_pkg::sub_t      row_sub_reg;
    ybd_pkg::sub_t      row_sub_next;
    ybd_pkg::tc_t       row_blk_reg;
    ybd_pkg::tc_t       row_blk_next;

    ybd_pkg::acc_word_t acc_mem [ybd_pkg::THUMB_SIDE];
    ybd_pkg::acc_word_t acc_rd_reg;
    logic [ybd_pkg::THUMB_SIDE-1:0] acc_ok_reg;
    logic               fwd_hit_reg;
    logic               fwd_hit_next;
    ybd_pkg::acc_word_t fwd_data_reg;

    logic               s1_valid_reg;
    logic               s1_done_reg;
    ybd_pkg::tc_t       s1_tc_reg;
    ybd_pkg::tc_t       s1_tr_reg;
    logic [7:0]         s1_luma_reg;
    logic [7:0]         s1_cb_reg;
    logic [7:0]         s1_cr_reg;
    ybd_pkg::acc_word_t acc_old;
    ybd_pkg::acc_word_t acc_sum;
    ybd_pkg::acc_word_t acc_wr;

    logic               s2_valid_reg;
    ybd_pkg::tc_t       s2_tc_reg;
    ybd_pkg::tc_t       s2_tr_reg;
    ybd_pkg::acc_word_t s2_sum_reg;

    chroma_pair_t       up_mem [ybd_pkg::THUMB_SIDE];
    chroma_pair_t       up_cur_reg;
    chroma_pair_t       up_prev_reg;

    logic               s3_valid_reg;
    ybd_pkg::tc_t       s3_tc_reg;
    ybd_pkg::tc_t       s3_tr_reg;
    logic [7:0]         s3_luma_reg;
    chroma_pair_t       s3_chroma_reg;
    chroma_pair_t       left_reg;

    logic [9:0]         cb_group;
    logic [9:0]         cr_group;
    logic               chroma_on;
    ybd_pkg::result_t   result;

    ybd_pkg::cnt_t      fifo_count;
    ybd_pkg::occ_t      occupancy;

    assign accept  = pix.valid && pix.ready;
    assign done_in = (col_sub_reg == ybd_pkg::sub_t'(ybd_pkg::BLOCK_FACTOR - 1)) &&
                     (row_sub_reg == ybd_pkg::sub_t'(ybd_pkg::BLOCK_FACTOR - 1));

    assign occupancy = ybd_pkg::occ_t'(fifo_count) +
                       ybd_pkg::occ_t'(s1_valid_reg && s1_done_reg) +
                       ybd_pkg::occ_t'(s2_valid_reg) +
                       ybd_pkg::occ_t'(s3_valid_reg);
    assign pix.ready = (occupancy < ybd_pkg::occ_t'(ybd_pkg::OUT_DEPTH));

    always_comb
    begin
        col_sub_next = col_sub_reg;
        col_blk_next = col_blk_reg;
        row_sub_next = row_sub_reg;
        row_blk_next = row_blk_reg;
        if (accept)
        begin
            if (col_sub_reg == ybd_pkg::sub_t'(ybd_pkg::BLOCK_FACTOR - 1))
            begin
                col_sub_next = '0;
                if (col_blk_reg == ybd_pkg::tc_t'(ybd_pkg::THUMB_SIDE - 1))
                begin
                    col_blk_next = '0;
                    if (row_sub_reg == ybd_pkg::sub_t'(ybd_pkg::BLOCK_FACTOR - 1))
                    begin
                        row_sub_next = '0;
                        row_blk_next = (row_blk_reg == ybd_pkg::tc_t'(ybd_pkg::THUMB_SIDE - 1)) ?
                                       '0 : row_blk_reg + ybd_pkg::tc_t'(1);
                    end
                    else
                    begin
                        row_sub_next = row_sub_reg + ybd_pkg::sub_t'(1);
                    end
                end
                else
                begin
                    col_blk_next = col_blk_reg + ybd_pkg::tc_t'(1);
                end
            end
            else
            begin
                col_sub_next = col_sub_reg + ybd_pkg::sub_t'(1);
            end
        end
    end

    // read-modify-write of the block sums
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            acc_old = fwd_data_reg;
        end
        else if (acc_ok_reg[s1_tc_reg])
        begin
            acc_old = acc_rd_reg;
        end
        else
        begin
            acc_old = '0;
        end
        acc_sum.luma = acc_old.luma + ybd_pkg::acc_t'(s1_luma_reg);
        acc_sum.cb   = acc_old.cb + ybd_pkg::acc_t'(s1_cb_reg);
        acc_sum.cr   = acc_old.cr + ybd_pkg::acc_t'(s1_cr_reg);
        acc_wr       = s1_done_reg ? '0 : acc_sum;
    end

    assign fwd_hit_next = accept && s1_valid_reg && (col_blk_reg == s1_tc_reg);

    always_comb
    begin
        chroma_on = s3_tr_reg[0] && s3_tc_reg[0];
        cb_group  = 10'(up_prev_reg.cb) + 10'(up_cur_reg.cb) + 10'(left_reg.cb) +
                    10'(s3_chroma_reg.cb);
        cr_group  = 10'(up_prev_reg.cr) + 10'(up_cur_reg.cr) + 10'(left_reg.cr) +
                    10'(s3_chroma_reg.cr);
        result.thumb_col    = 4'(s3_tc_reg);
        result.thumb_row    = 4'(s3_tr_reg);
        result.luma_avg     = s3_luma_reg;
        result.chroma_valid = chroma_on;
        result.cb_avg       = chroma_on ? cb_group[9:2] : 8'd0;
        result.cr_avg       = chroma_on ? cr_group[9:2] : 8'd0;
        result.frame_last   = (s3_tc_reg == ybd_pkg::tc_t'(ybd_pkg::THUMB_SIDE - 1)) &&
                              (s3_tr_reg == ybd_pkg::tc_t'(ybd_pkg::THUMB_SIDE - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_sub_reg  <= '0;
            col_blk_reg  <= '0;
            row_sub_reg  <= '0;
            row_blk_reg  <= '0;
            acc_ok_reg   <= '0;
            fwd_hit_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            col_sub_reg  <= col_sub_next;
            col_blk_reg  <= col_blk_next;
            row_sub_reg  <= row_sub_next;
            row_blk_reg  <= row_blk_next;
            fwd_hit_reg  <= fwd_hit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_done_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                acc_ok_reg[s1_tc_reg] <= 1'b1;
            end
            if (s3_valid_reg && s3_tr_reg[0] && !s3_tc_reg[0])
            begin
                left_reg <= s3_chroma_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_done_reg <= done_in;
            s1_tc_reg   <= col_blk_reg;
            s1_tr_reg   <= row_blk_reg;
            s1_luma_reg <= pix.luma_in;
            s1_cb_reg   <= pix.cb_in;
            s1_cr_reg   <= pix.cr_in;
        end
        fwd_data_reg <= acc_wr;

        s2_tc_reg  <= s1_tc_reg;
        s2_tr_reg  <= s1_tr_reg;
        s2_sum_reg <= acc_sum;

        s3_tc_reg        <= s2_tc_reg;
        s3_tr_reg        <= s2_tr_reg;
        s3_luma_reg      <= ybd_pkg::block_avg(s2_sum_reg.luma);
        s3_chroma_reg.cb <= ybd_pkg::block_avg(s2_sum_reg.cb);
        s3_chroma_reg.cr <= ybd_pkg::block_avg(s2_sum_reg.cr);
    end

    always_ff @(posedge clk)
    begin
        acc_rd_reg <= acc_mem[col_blk_reg];
        if (s1_valid_reg)
        begin
            acc_mem[s1_tc_reg] <= acc_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        up_cur_reg  <= up_mem[s2_tc_reg];
        up_prev_reg <= up_mem[s2_tc_reg - ybd_pkg::tc_t'(1)];
        if (s3_valid_reg && !s3_tr_reg[0])
        begin
            up_mem[s3_tc_reg] <= s3_chroma_reg;
        end
    end

    ybd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_word (result),
        .count     (fifo_count),
        .thumb     (thumb)
    );

endmodule

/* hdl/ybd_checker.sv */
module ybd_checker (
    input  logic        clk,
    input  logic        rst_n,
    ybd_pix_if.sink     pix,
    ybd_thumb_if.source thumb
);

    logic seen_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg <= 1'b0;
        end
        else if (pix.valid && pix.ready)
        begin
            seen_in_reg <= 1'b1;
        end
    end

    a_no_word_without_pixel: assert property (
        @(posedge clk) disable iff (!rst_n)
        thumb.valid |-> seen_in_reg
    ) else $error("thumbnail word shown before any pixel word was taken");

    a_chroma_on_odd_block: assert property (
        @(posedge clk) disable iff (!rst_n)
        thumb.valid && thumb.chroma_valid |-> thumb.thumb_col[0] && thumb.thumb_row[0]
    ) else $error("chroma attached to a block that is not odd in row and column");

    a_last_is_corner: assert property (
        @(posedge clk) disable iff (!rst_n)
        thumb.valid && thumb.frame_last |->
            thumb.thumb_col == 4'(ybd_pkg::THUMB_SIDE - 1) &&
            thumb.thumb_row == 4'(ybd_pkg::THUMB_SIDE - 1)
    ) else $error("frame end flagged away from the bottom-right block");

    a_hold_stalled_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        thumb.valid && !thumb.ready |=>
            thumb.valid && $stable(thumb.luma_avg) && $stable(thumb.thumb_col) &&
            $stable(thumb.thumb_row) && $stable(thumb.cb_avg) && $stable(thumb.cr_avg)
    ) else $error("stalled thumbnail word changed");

endmodule

bind yuv_box_downsample_420 ybd_checker u_ybd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .pix   (pix),
    .thumb (thumb)
);

/* dv/tb_yuv_box_downsample_420.sv */
`timescale 1ns / 100ps

module tb_yuv_box_downsample_420;

    localparam int SRC_SIDE    = ybd_pkg::THUMB_SIDE * ybd_pkg::BLOCK_FACTOR;
    localparam int BAND_PIXELS = SRC_SIDE * ybd_pkg::BLOCK_FACTOR;
    localparam int NUM_PIXELS  = 1850;
    localparam int PHASE_LEN   = 300;
    localparam int NUM_DIRECT  = 24;

    typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_MAX, PAT_MIN, PAT_HIGH, PAT_LOW} pat_t;

    class thumb_scoreboard;
        int        src_col;
        int        src_row;
        ybd_pkg::acc_t luma_sum [ybd_pkg::THUMB_SIDE];
        ybd_pkg::acc_t cb_sum   [ybd_pkg::THUMB_SIDE];
        ybd_pkg::acc_t cr_sum   [ybd_pkg::THUMB_SIDE];
        logic [7:0] cb_upper [ybd_pkg::THUMB_SIDE];
        logic [7:0] cr_upper [ybd_pkg::THUMB_SIDE];
        logic [7:0] cb_left;
        logic [7:0] cr_left;
        ybd_pkg::result_t expected_q [$];
        int        errors;

        function new();
            src_col = 0;
            src_row = 0;
            cb_left = '0;
            cr_left = '0;
            errors  = 0;
            for (int i = 0; i < ybd_pkg::THUMB_SIDE; i++)
            begin
                luma_sum[i] = '0;
                cb_sum[i]   = '0;
                cr_sum[i]   = '0;
                cb_upper[i] = '0;
                cr_upper[i] = '0;
            end
        endfunction

        function void note_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
            int               tc;
            int               tr;
            ybd_pkg::result_t r;
            logic [7:0]       bu;
            logic [7:0]       bv;
            logic [9:0]       su;
            logic [9:0]       sv;
            tc = (src_col / ybd_pkg::BLOCK_FACTOR) % ybd_pkg::THUMB_SIDE;
            tr = (src_row / ybd_pkg::BLOCK_FACTOR) % ybd_pkg::THUMB_SIDE;
            luma_sum[tc] = luma_sum[tc] + y;
            cb_sum[tc]   = cb_sum[tc] + u;
            cr_sum[tc]   = cr_sum[tc] + v;
            if (src_col % ybd_pkg::BLOCK_FACTOR == ybd_pkg::BLOCK_FACTOR - 1 &&
                src_row % ybd_pkg::BLOCK_FACTOR == ybd_pkg::BLOCK_FACTOR - 1)
            begin
                r            = '0;
                r.thumb_col  = 4'(tc);
                r.thumb_row  = 4'(tr);
                r.luma_avg   = 8'(luma_sum[tc] / ybd_pkg::BLOCK_AREA);
                bu           = 8'(cb_sum[tc] / ybd_pkg::BLOCK_AREA);
                bv           = 8'(cr_sum[tc] / ybd_pkg::BLOCK_AREA);
                luma_sum[tc] = '0;
                cb_sum[tc]   = '0;
                cr_sum[tc]   = '0;
                if (tr % 2 == 0)
                begin
                    cb_upper[tc] = bu;
                    cr_upper[tc] = bv;
                end
                else if (tc % 2 == 0)
                begin
                    cb_left = bu;
                    cr_left = bv;
                end
                else
                begin
                    su = 10'(cb_upper[tc-1]) + 10'(cb_upper[tc]) + 10'(cb_left) + 10'(bu);
                    sv = 10'(cr_upper[tc-1]) + 10'(cr_upper[tc]) + 10'(cr_left) + 10'(bv);
                    r.chroma_valid = 1'b1;
                    r.cb_avg       = 8'(su / 4);
                    r.cr_avg       = 8'(sv / 4);
                end
                r.frame_last = (tc == ybd_pkg::THUMB_SIDE - 1 && tr == ybd_pkg::THUMB_SIDE - 1);
                expected_q.push_back(r);
            end
            src_col++;
            if (src_col >= SRC_SIDE)
            begin
                src_col = 0;
                src_row++;
                if (src_row >= SRC_SIDE)
                    src_row = 0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want, ybd_pkg::result_t exp_word);
            if (got != want)
                report($sformatf("%s got %0d want %0d (col %0d row %0d)",
                                 name, got, want, exp_word.thumb_col, exp_word.thumb_row));
        endtask

        task check(ybd_pkg::result_t got);
            ybd_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected word col %0d row %0d",
                                 got.thumb_col, got.thumb_row));
                return;
            end
            want = expected_q.pop_front();
            compare_field("thumb_col", got.thumb_col, want.thumb_col, want);
            compare_field("thumb_row", got.thumb_row, want.thumb_row, want);
            compare_field("luma_avg", got.luma_avg, want.luma_avg, want);
            compare_field("chroma_valid", got.chroma_valid, want.chroma_valid, want);
            compare_field("cb_avg", got.cb_avg, want.cb_avg, want);
            compare_field("cr_avg", got.cr_avg, want.cr_avg, want);
            compare_field("frame_last", got.frame_last, want.frame_last, want);
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;

    thumb_scoreboard sb;

    ybd_pix_if   pix ();
    ybd_thumb_if thumb ();

    yuv_box_downsample_420 i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .thumb (thumb)
    );

    logic [7:0] dir_luma [NUM_DIRECT] = '{
        8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80,
        8'hFE, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h0F,
        8'hF0, 8'h33, 8'hCC, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFF
    };
    logic [7:0] dir_cb [NUM_DIRECT] = '{
        8'h00, 8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01,
        8'h7F, 8'hFE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hF0,
        8'h0F, 8'hCC, 8'h33, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFF
    };
    logic [7:0] dir_cr [NUM_DIRECT] = '{
        8'hFF, 8'hFF, 8'h00, 8'h00, 8'h55, 8'hAA, 8'hFE, 8'h02,
        8'h01, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h3C,
        8'hC3, 8'h96, 8'h69, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF
    };

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_pct > 0)
            thumb.ready <= ($urandom_range(0, 99) >= stall_pct);
        else
            thumb.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        ybd_pkg::result_t got;
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
                sb.note_pixel(pix.luma_in, pix.cb_in, pix.cr_in);
            if (thumb.valid && thumb.ready)
            begin
                got.thumb_col    = thumb.thumb_col;
                got.thumb_row    = thumb.thumb_row;
                got.luma_avg     = thumb.luma_avg;
                got.chroma_valid = thumb.chroma_valid;
                got.cb_avg       = thumb.cb_avg;
                got.cr_avg       = thumb.cr_avg;
                got.frame_last   = thumb.frame_last;
                sb.check(got);
            end
        end
    end

    task set_idling(int phase);
        case (phase % 4)
            0:
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            1:
            begin
                gap_pct   = 50;
                stall_pct = 0;
            end
            2:
            begin
                gap_pct   = 0;
                stall_pct = 50;
            end
            default:
            begin
                gap_pct   = 7;
                stall_pct = 7;
            end
        endcase
    endtask

    task send_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
        pix.valid   <= 1'b1;
        pix.luma_in <= y;
        pix.cb_in   <= u;
        pix.cr_in   <= v;
        do
            @(posedge clk);
        while (!pix.ready);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_sample(pat_t pat);
        case (pat)
            PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PAT_MAX:     return 8'hFF;
            PAT_MIN:     return 8'h00;
            PAT_HIGH:    return 8'($urandom_range(240, 255));
            PAT_LOW:     return 8'($urandom_range(0, 15));
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pat_t pick_pattern();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            5:       return PAT_EXTREME;
            6:       return PAT_MAX;
            7:       return PAT_MIN;
            8:       return PAT_HIGH;
            9:       return PAT_LOW;
            default: return PAT_RANDOM;
        endcase
    endfunction

    initial
    begin
        pat_t luma_pat;
        pat_t cb_pat;
        pat_t cr_pat;
        sb            = new();
        rst_n         = 1'b0;
        pix.valid     = 1'b0;
        pix.luma_in   = '0;
        pix.cb_in     = '0;
        pix.cr_in     = '0;
        thumb.ready   = 1'b0;
        luma_pat      = PAT_RANDOM;
        cb_pat        = PAT_RANDOM;
        cr_pat        = PAT_RANDOM;
        set_idling(0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < NUM_PIXELS; n++)
        begin
            if (n % PHASE_LEN == 0)
                set_idling(n / PHASE_LEN);
            if (n < NUM_DIRECT)
                send_pixel(dir_luma[n], dir_cb[n], dir_cr[n]);
            else
            begin
                if (n % BAND_PIXELS == 0 || n == NUM_DIRECT)
                begin
                    luma_pat = pick_pattern();
                    cb_pat   = pick_pattern();
                    cr_pat   = pick_pattern();
                end
                send_pixel(pick_sample(luma_pat), pick_sample(cb_pat), pick_sample(cr_pat));
            end
        end
        pix.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
